// ===== sv/stwa_pkg.sv =====
// ----------------------------------------------------------------------------
// stwa_pkg
// Shared types and constants for the stalled event window alarm.
// ----------------------------------------------------------------------------
package stwa_pkg;

    localparam int unsigned LIFETIME_BITS  = 32;
    localparam int unsigned THRESH_BITS    = 6;
    localparam int unsigned NOW_BITS       = 32;
    localparam int unsigned EVCOUNT_BITS   = 7;
    localparam int unsigned CFG_ADDR_BITS  = 1;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned IN_DATA_BITS   = 32;
    localparam int unsigned OUT_DATA_BITS  = 8;

    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LIFETIME = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ALARM_THRESHOLD = 1'd1;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FIN
    } t_state;

endpackage

// ===== sv/stalled_event_window_alarm.sv =====
// ----------------------------------------------------------------------------
// stalled_event_window_alarm
// Sliding window event counter: a circular stamp memory trimmed by age and
// by the alarm threshold, one count/alert beat per input beat.
//
// channel   dir  tdata                         tuser
// s_axis    in   [31:0] now_time               [0] command
// m_axis    out  [6:0] event_count, [7] alert  -
// cfg       in   index 0 window_lifetime, 1 alarm_threshold
//
// An accepted beat runs ST_READ, ST_CMP, ST_FIN to the output register (only
// ST_FIN with a zero threshold; ST_READ, ST_FIN with an empty window); entries
// dropped over the threshold repeat ST_READ, by age ST_READ and ST_CMP, which
// tests the registered stamp read. Reset is synchronous; the stamp memory is not
// cleared. A new beat is taken while a result waits in the output register; the
// sequencer holds its finished result until that register is free.
// ----------------------------------------------------------------------------
module stalled_event_window_alarm
    import stwa_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned TIME_BITS   = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [31:0] now_time
    input  logic                     s_axis_tuser,   // [0] command
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata    // [6:0] event_count, [7] alert
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned KW = (CW > THRESH_BITS) ? CW : THRESH_BITS;
    localparam int unsigned XW = (TIME_BITS > LIFETIME_BITS) ? TIME_BITS : LIFETIME_BITS;
    localparam logic [AW:0] DEPTH_X = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    logic [TIME_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] r_rdata;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [LIFETIME_BITS-1:0] r_lifetime;
    logic [THRESH_BITS-1:0]   r_thresh;
    logic [TIME_BITS-1:0]     r_now, n_now;
    logic                     r_out_valid, n_out_valid;
    logic [EVCOUNT_BITS-1:0]  r_out_count, n_out_count;
    logic                     r_out_alert, n_out_alert;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic                     mem_re;
    logic [AW:0]              wsum;
    logic [TIME_BITS-1:0]     in_now;
    logic                     full;
    logic                     over;
    logic                     stale;
    logic [XW-1:0]            age;
    logic                     in_fire;
    logic                     out_free;

    assign in_now   = TIME_BITS'(s_axis_tdata);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign full     = (r_count >= DEPTH_C);
    assign over     = (KW'(r_count) > KW'(r_thresh));
    assign wsum     = {1'b0, r_head} + (AW+1)'(r_count);
    assign mem_waddr = (wsum >= DEPTH_X) ? AW'(wsum - DEPTH_X) : AW'(wsum);
    assign age      = XW'(r_now) - XW'(r_rdata);
    assign stale    = (r_rdata <= r_now) && (age > XW'(r_lifetime));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_alert, r_out_count};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= in_now;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= '0;
            r_thresh   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WINDOW_LIFETIME: r_lifetime <= i_cfg_data[LIFETIME_BITS-1:0];
                REG_ALARM_THRESHOLD: r_thresh   <= i_cfg_data[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_now       <= n_now;
        r_out_count <= n_out_count;
        r_out_alert <= n_out_alert;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_now       = r_now;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_count = r_out_count;
        n_out_alert = r_out_alert;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_now = in_now;
                    if (r_thresh == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_READ;
                        if (s_axis_tuser == CMD_RECORD) begin
                            mem_we = 1'b1;
                            if (full) begin
                                n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                if (r_count == '0) begin
                    n_state = ST_FIN;
                end else if (over) begin
                    n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (stale) begin
                    n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = ST_READ;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = EVCOUNT_BITS'(r_count);
                    n_out_alert = (r_thresh != '0) && (KW'(r_count) >= KW'(r_thresh));
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/stwa_checker.sv =====
// ----------------------------------------------------------------------------
// stwa_checker
// Port-level checks for the stalled event window alarm, bound to the top.
// ----------------------------------------------------------------------------
module stwa_checker
    import stwa_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_alert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6:0] != 7'd0)
        else $error("alert raised with an empty window");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[6])
        else $error("event count above the largest threshold");

    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input beat taken while the previous one is in work");

endmodule

bind stalled_event_window_alarm stwa_checker u_stwa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
